@@ design/pls_pkg.sv @@
// Shared types and constants for the positional list store.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package pls_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 5;
  localparam int OCC_W       = 5;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CMP_W       = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   slot;
    logic [IDX_W-1:0]   last_idx;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/positional_list_store.sv @@
// Top level of the positional list store: command control, output register, cell chain.
// Depends on pls_pkg, pls_chain.
//
//   channel | signals                                  | transaction
//   in      | in_valid, in_ready, cmd/at_end/pos/value | one command
//   out     | out_valid, out_ready, status/item/occ/last | one result
//
// Insert and delete shift all cells in parallel at acceptance.
// A dump rotates the occupied cells one step per cycle, one result per cycle, while the
// output register is free; the next command is taken once every occupied cell has rotated.
// A held output register stalls the dump rotation and blocks new commands.
// Reset clears the element count; cell contents are left as they are.
`default_nettype none

module positional_list_store
  import pls_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               cmd,
  input  wire logic                     at_end,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [1:0]                    status,
  output logic signed [DATA_W-1:0]      item,
  output logic [OCC_W-1:0]              occupancy,
  output logic                          last
);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  dump_idx, dump_idx_next;
  logic              out_valid_next;
  logic [1:0]        status_next;
  logic [DATA_W-1:0] item_next;
  logic [OCC_W-1:0]  occupancy_next;
  logic              last_next;

  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] head_data;
  logic [DATA_W-1:0] sel_data;

  logic              accept;
  logic              out_free;
  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  cnt_w;
  logic [IDX_W-1:0]  pos_m1;
  logic [IDX_W-1:0]  last_idx;
  logic [1:0]        ins_st;
  logic [1:0]        del_st;
  logic [IDX_W-1:0]  ins_slot;
  logic [IDX_W-1:0]  del_slot;
  int                dump_len;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !rst && (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  assign pos_w    = CMP_W'(position);
  assign cnt_w    = CMP_W'(count);
  assign pos_m1   = IDX_W'(pos_w - CMP_W'(1));
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign dump_len = (int'(count) < MAX_RESULTS) ? int'(count) : MAX_RESULTS;

  always_comb begin
    if (int'(count) >= CAPACITY) begin
      ins_st = ST_FULL;
    end else if (!at_end && (pos_w == '0 || pos_w > cnt_w + CMP_W'(1))) begin
      ins_st = ST_RANGE;
    end else begin
      ins_st = ST_OK;
    end
    ins_slot = at_end ? IDX_W'(count) : pos_m1;

    if (count == '0) begin
      del_st = ST_EMPTY;
    end else if (!at_end && (pos_w == '0 || pos_w > cnt_w)) begin
      del_st = ST_RANGE;
    end else begin
      del_st = ST_OK;
    end
    del_slot = at_end ? last_idx : pos_m1;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    dump_idx_next  = dump_idx;
    out_valid_next = out_valid && !out_ready;
    status_next    = status;
    item_next      = item;
    occupancy_next = occupancy;
    last_next      = last;
    ctrl.op        = CELL_HOLD;
    ctrl.slot      = ins_slot;
    ctrl.last_idx  = last_idx;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_INSERT: begin
              if (ins_st == ST_OK) begin
                ctrl.op    = CELL_INS;
                count_next = count + CNT_W'(1);
              end
              out_valid_next = 1'b1;
              status_next    = ins_st;
              item_next      = '0;
              occupancy_next = OCC_W'(count_next);
              last_next      = 1'b1;
            end
            CMD_DELETE: begin
              ctrl.slot = del_slot;
              if (del_st == ST_OK) begin
                ctrl.op    = CELL_DEL;
                count_next = count - CNT_W'(1);
              end
              out_valid_next = 1'b1;
              status_next    = del_st;
              item_next      = (del_st == ST_OK) ? sel_data : '0;
              occupancy_next = OCC_W'(count_next);
              last_next      = 1'b1;
            end
            CMD_DUMP: begin
              if (count == '0) begin
                out_valid_next = 1'b1;
                status_next    = ST_EMPTY;
                item_next      = '0;
                occupancy_next = '0;
                last_next      = 1'b1;
              end else begin
                state_next    = S_DUMP;
                dump_idx_next = '0;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (int'(dump_idx) >= MAX_RESULTS || out_free) begin
          ctrl.op = CELL_ROT;
          if (int'(dump_idx) < MAX_RESULTS) begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            item_next      = head_data;
            occupancy_next = OCC_W'(count);
            last_next      = (int'(dump_idx) + 1 == dump_len);
          end
          dump_idx_next = dump_idx + CNT_W'(1);
          if (dump_idx_next == count) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dump_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dump_idx  <= dump_idx_next;
      out_valid <= out_valid_next;
    end
    status    <= status_next;
    item      <= $signed(item_next);
    occupancy <= occupancy_next;
    last      <= last_next;
  end

  pls_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .ins_value ($unsigned(value)),
    .sel       (del_slot),
    .head_data (head_data),
    .sel_data  (sel_data)
  );

endmodule

`default_nettype wire

@@ design/pls_cell.sv @@
// One storage cell of the list chain: holds one element, shifts with its neighbors.
// Depends on pls_pkg.
`default_nettype none

module pls_cell
  import pls_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic [DATA_W-1:0] right_data,
  input  wire logic [DATA_W-1:0] head_data,
  input  wire logic [DATA_W-1:0] ins_value,
  output logic      [DATA_W-1:0] data
);

  logic [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctrl.op)
      CELL_INS: begin
        if (idx > ctrl.slot) begin
          data_next = left_data;
        end else if (idx == ctrl.slot) begin
          data_next = ins_value;
        end
      end
      CELL_DEL: begin
        if (idx >= ctrl.slot && idx < ctrl.last_idx) begin
          data_next = right_data;
        end
      end
      CELL_ROT: begin
        if (idx == ctrl.last_idx) begin
          data_next = head_data;
        end else if (idx < ctrl.last_idx) begin
          data_next = right_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

@@ design/pls_chain.sv @@
// Row of list cells with neighbor wiring, head tap and one selected read port.
// Depends on pls_pkg and pls_cell.
`default_nettype none

module pls_chain
  import pls_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] ins_value,
  input  wire logic [IDX_W-1:0]  sel,
  output logic      [DATA_W-1:0] head_data,
  output logic      [DATA_W-1:0] sel_data
);

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] left_tap  [CAPACITY];
  logic [DATA_W-1:0] right_tap [CAPACITY];

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    if (gi == 0) begin : g_first
      assign left_tap[gi] = '0;
    end else begin : g_inner_left
      assign left_tap[gi] = cell_data[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right_tap[gi] = '0;
    end else begin : g_inner_right
      assign right_tap[gi] = cell_data[gi+1];
    end

    pls_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(gi)),
      .left_data  (left_tap[gi]),
      .right_data (right_tap[gi]),
      .head_data  (head_data),
      .ins_value  (ins_value),
      .data       (cell_data[gi])
    );
  end

  assign head_data = cell_data[0];
  assign sel_data  = cell_data[sel];

endmodule

`default_nettype wire

@@ design/pls_checker.sv @@
// Port-level checker for the positional list store, bound to the top level.
// Depends on pls_pkg and positional_list_store.
`default_nettype none

module pls_checker
  import pls_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic [1:0]               cmd,
  input wire logic                     at_end,
  input wire logic [POS_W-1:0]         position,
  input wire logic signed [DATA_W-1:0] value,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [1:0]               status,
  input wire logic signed [DATA_W-1:0] item,
  input wire logic [OCC_W-1:0]         occupancy,
  input wire logic                     last
);

  a_err_item_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> item == '0)
    else $error("non-ok result carries a nonzero item");

  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> occupancy == '0 && last)
    else $error("empty result with nonzero occupancy or without last");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> occupancy == OCC_W'(CAPACITY) && last)
    else $error("full result with wrong occupancy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(item) && $stable(status) && $stable(last))
    else $error("stalled result changed");

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);

`default_nettype wire

@@ verif/list_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the positional list store: predicts every result of each
// accepted command and compares accepted results in order. Depends on pls_pkg.

module list_result_checker
  import pls_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire logic [1:0]          cmd,
  input  wire logic                at_end,
  input  wire logic [POS_W-1:0]    position,
  input  wire logic [DATA_W-1:0]   value,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire logic [1:0]          status,
  input  wire logic [DATA_W-1:0]   item,
  input  wire logic [OCC_W-1:0]    occupancy,
  input  wire logic                last,
  output int                       fail_count,
  output int                       due_count,
  output int                       list_len
);

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] item;
    logic [OCC_W-1:0]  occ;
    logic              last;
  } list_result_t;

  list_result_t      due_results[$];
  logic [DATA_W-1:0] cells[CAPACITY];
  int                cells_used;

  task automatic report_mismatch(input string msg);
    if (fail_count < 50) $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic push_result(input logic [1:0] st, input logic [DATA_W-1:0] it,
                             input logic lst);
    due_results.push_back({st, it, cells_used[OCC_W-1:0], lst});
  endtask

  task automatic apply_list_cmd(input logic [1:0] op, input logic ae,
                                input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
    int                slot;
    int                n;
    int                i;
    logic [1:0]        st;
    logic [DATA_W-1:0] gone;
    st   = ST_OK;
    gone = '0;
    case (op)
      CMD_INSERT: begin
        slot = cells_used;
        if (cells_used >= CAPACITY) st = ST_FULL;
        else if (!ae) begin
          if (pos < 1 || pos > cells_used + 1) st = ST_RANGE;
          else slot = int'(pos) - 1;
        end
        if (st == ST_OK) begin
          for (i = cells_used; i > slot; i--) cells[i] = cells[i-1];
          cells[slot] = val;
          cells_used++;
        end
        push_result(st, '0, 1'b1);
      end
      CMD_DELETE: begin
        slot = cells_used - 1;
        if (cells_used == 0) st = ST_EMPTY;
        else if (!ae) begin
          if (pos < 1 || pos > cells_used) st = ST_RANGE;
          else slot = int'(pos) - 1;
        end
        if (st == ST_OK) begin
          gone = cells[slot];
          for (i = slot; i + 1 < cells_used; i++) cells[i] = cells[i+1];
          cells_used--;
        end
        push_result(st, gone, 1'b1);
      end
      CMD_DUMP: begin
        if (cells_used == 0) push_result(ST_EMPTY, '0, 1'b1);
        else begin
          n = (cells_used < MAX_RESULTS) ? cells_used : MAX_RESULTS;
          for (i = 0; i < n; i++) push_result(ST_OK, cells[i], i == n - 1);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    list_result_t want;
    list_result_t got;
    if (rst) begin
      due_results.delete();
      cells_used = 0;
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {status, item, occupancy, last};
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing due: %p", got));
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.item !== want.item)
            report_mismatch($sformatf("item %h, want %h", got.item, want.item));
          if (got.occ !== want.occ)
            report_mismatch($sformatf("occupancy %0d, want %0d", got.occ, want.occ));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        end
      end
      if (in_valid && in_ready) apply_list_cmd(cmd, at_end, position, value);
    end
    due_count <= due_results.size();
    list_len  <= cells_used;
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the positional list store: clock, reset, command stimulus,
// receiver stalls and verdict. Depends on pls_pkg and list_result_checker.

module tb;
  import pls_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         PHASE_ITEMS  = 75;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [1:0]               cmd       = CMD_INSERT;
  logic                     at_end    = 1'b0;
  logic [POS_W-1:0]         position  = '0;
  logic signed [DATA_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] item;
  logic [OCC_W-1:0]         occupancy;
  logic                     last;

  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic hold_req     = 1'b0;
  logic hold_taken   = 1'b0;
  int   hold_left    = 0;
  int   cycles       = 0;
  int   fail_count;
  int   due_count;
  int   list_len;

  always #5 clk = ~clk;

  positional_list_store dut (
    .clk, .rst, .in_valid, .in_ready, .cmd, .at_end, .position, .value,
    .out_valid, .out_ready, .status, .item, .occupancy, .last
  );

  list_result_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .cmd, .at_end, .position, .value,
    .out_valid, .out_ready, .status, .item, .occupancy, .last,
    .fail_count, .due_count, .list_len
  );

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic offer_cmd(input logic [1:0] op, input logic ae,
                           input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] val);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    at_end   <= ae;
    position <= pos;
    value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    int                ph;
    int                k;
    int                r;
    logic [1:0]        op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    bit                fill;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_cmd(CMD_DUMP,   1'b0, 5'd0,  32'd0);
    offer_cmd(CMD_DELETE, 1'b1, 5'd0,  32'd0);
    offer_cmd(CMD_DELETE, 1'b0, 5'd1,  32'd0);
    offer_cmd(CMD_UNUSED, 1'b1, 5'd31, 32'hffff_ffff);
    offer_cmd(CMD_INSERT, 1'b0, 5'd0,  32'h1234_5678);
    offer_cmd(CMD_INSERT, 1'b0, 5'd2,  32'h1234_5678);
    offer_cmd(CMD_INSERT, 1'b0, 5'd1,  32'h8000_0000);
    offer_cmd(CMD_INSERT, 1'b1, 5'd31, 32'h7fff_ffff);
    offer_cmd(CMD_INSERT, 1'b0, 5'd3,  32'hffff_ffff);
    offer_cmd(CMD_INSERT, 1'b0, 5'd1,  32'h0000_0000);
    offer_cmd(CMD_INSERT, 1'b0, 5'd31, 32'h5555_aaaa);
    offer_cmd(CMD_DUMP,   1'b0, 5'd0,  32'd0);
    offer_cmd(CMD_DELETE, 1'b0, 5'd0,  32'd0);
    offer_cmd(CMD_DELETE, 1'b0, 5'd5,  32'd0);
    offer_cmd(CMD_DELETE, 1'b0, 5'd2,  32'd0);
    offer_cmd(CMD_DELETE, 1'b1, 5'd0,  32'd0);
    offer_cmd(CMD_DELETE, 1'b0, 5'd1,  32'd0);
    offer_cmd(CMD_DUMP,   1'b0, 5'd0,  32'd0);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
        default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // stall the receiver for a long stretch while a command waits on in_ready
        if (ph == 0 && k == 10) hold_req <= 1'b1;
        fill = ((k / 25) % 2) == 0;
        r = $urandom_range(99);
        if (r < (fill ? 75 : 15)) op = CMD_INSERT;
        else if (r < 88)          op = CMD_DELETE;
        else if (r < 97)          op = CMD_DUMP;
        else                      op = CMD_UNUSED;
        if ($urandom_range(9) == 0) pos = POS_W'($urandom);
        else                        pos = POS_W'($urandom_range(list_len + 1, 0));
        if ($urandom_range(7) == 0) begin
          case ($urandom_range(3))
            0: val = 32'h8000_0000;
            1: val = 32'h7fff_ffff;
            2: val = '1;
            default: val = '0;
          endcase
        end else begin
          val = $urandom;
        end
        offer_cmd(op, $urandom_range(3) == 0, pos, val);
      end
    end

    in_valid <= 1'b0;
    rx_stall_pct = 0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
